// ----- design/pid_pkg.sv -----
// Shared types and constants for the PID controller step block.
// Used by pid_mul and pid_controller_step_top; no other dependencies.
package pid_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_IN_MIN   = 3'd3,
    REG_IN_MAX   = 3'd4,
    REG_OUT_MIN  = 3'd5,
    REG_OUT_MAX  = 3'd6,
    REG_CONT     = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLMP,
    S_ERR,
    S_WRAP,
    S_SAT,
    S_CAND,
    S_MSET,
    S_MGO,
    S_MWAIT,
    S_MPOST,
    S_MACC,
    S_OCLAMP,
    S_DONE
  } state_t;

  // Product slots: integrator check, then the three PID terms
  typedef enum logic [1:0] {
    T_INT,
    T_P,
    T_I,
    T_D
  } term_t;

  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 48;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_A_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam logic [30:0] OUT_MAX_RESET = 31'd65536;
  localparam logic [46:0] TERM_LIMIT    = 47'h4000_0000_0000;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ----- design/pid_controller_step_top.sv -----
// PID controller step with integrator anti-windup, signed Q16.16.
// Depends on pid_pkg and pid_mul (shared bit-serial multiplier).
//
// A command other than an enabled sample goes from S_IDLE straight to S_DONE,
// where its result is loaded into the result register. An enabled sample
// passes five setup steps, the integrator check product, three PID term
// products (each waiting on the shared multiplier plus four control steps),
// the output clamp and the result load. The multiplier sets the rate; the
// next item is taken only once the current one has been loaded, and a stalled
// full result register holds it in S_DONE. Reset (rst_n low, synchronous)
// clears the loop state, restores register defaults and empties the output
// register.
module pid_controller_step_top (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_measurement,
  input  logic signed [31:0] in_target,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic signed [32:0] out_loop_error,
  output logic               out_running,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pid_pkg::*;

  // configuration registers
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0]        in_min_r, in_max_r, out_min_r, out_max_r;
  logic               cont_r;

  // loop state
  state_t             state_r, state_nxt;
  term_t              k_r;
  logic               en_r;
  logic signed [47:0] sum_r;
  logic signed [32:0] prev_r;
  logic signed [32:0] last_error_r;
  logic signed [31:0] drive_r;

  // per-sample scratch
  logic signed [31:0] meas_r, tgt_r;
  logic signed [34:0] err_r;
  logic signed [47:0] cand_r;
  logic signed [33:0] diff_r;
  logic [31:0]        mul_a_r;
  logic [47:0]        mul_b_r;
  logic               neg_r;
  logic [46:0]        term_r;
  logic signed [48:0] acc_r;

  logic               out_valid_r;
  logic               in_acc, cfg_wr, mul_start, out_load;

  mul_req_t           mreq;
  mul_rsp_t           mrsp;

  pid_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign mreq.start = mul_start;
  assign mreq.a     = mul_a_r;
  assign mreq.b     = mul_b_r;

  // Magnitude clamp, sign kept; zero counts as positive.
  function automatic logic signed [31:0] mag_clamp32(logic signed [31:0] x,
                                                     logic [30:0] lo, logic [30:0] hi);
    logic [31:0] m;
    logic [31:0] r;
    logic signed [31:0] res;
    m = x[31] ? (~x + 32'd1) : x;
    if (m > {1'b0, hi}) begin
      r   = {1'b0, hi};
      res = x[31] ? (~r + 32'd1) : r;
    end else if (m < {1'b0, lo}) begin
      r   = {1'b0, lo};
      res = x[31] ? (~r + 32'd1) : r;
    end else begin
      res = x;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- datapath
  logic               in_clamp_on;
  logic signed [31:0] span;
  logic [33:0]        err_abs;
  logic               wrap_hit;
  logic signed [34:0] err_wrapped;
  logic               err_fits;
  logic signed [32:0] e_sat;
  logic signed [48:0] cand49;
  logic signed [47:0] cand_sat;
  logic signed [33:0] diff_nxt;
  logic signed [31:0] gsel;
  logic signed [47:0] opb;
  logic [31:0]        a_mag;
  logic [47:0]        b_mag;
  logic [80:0]        rounded;
  logic [64:0]        shifted;
  logic [46:0]        term_nxt;
  logic               integ_ok;
  logic [48:0]        acc_abs;
  logic [31:0]        oc_mag;
  logic signed [31:0] drive_nxt;

  always_comb begin
    in_clamp_on = in_max_r > in_min_r;
    span        = $signed({1'b0, in_max_r}) - $signed({1'b0, in_min_r});

    // shorter way round: compare 2*|e| against the span
    err_abs     = err_r[34] ? 34'(-err_r) : err_r[33:0];
    wrap_hit    = $signed({2'b00, err_abs, 1'b0}) > $signed({{5{span[31]}}, span});
    err_wrapped = (err_r > 0) ? err_r - {{3{span[31]}}, span}
                              : err_r + {{3{span[31]}}, span};

    err_fits = (err_r[34:32] == 3'b000) || (err_r[34:32] == 3'b111);
    e_sat    = err_fits ? err_r[32:0]
             : (err_r[34] ? 33'sh1_0000_0000 : 33'sh0_FFFF_FFFF);

    cand49   = {sum_r[47], sum_r} + {{16{last_error_r[32]}}, last_error_r};
    cand_sat = (cand49[48] == cand49[47]) ? cand49[47:0]
             : (cand49[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF);
    diff_nxt = {last_error_r[32], last_error_r} - {prev_r[32], prev_r};

    // operand select for the shared multiplier
    case (k_r)
      T_INT: begin
        gsel = gain_i_r;
        opb  = cand_r;
      end
      T_P: begin
        gsel = gain_p_r;
        opb  = {{15{last_error_r[32]}}, last_error_r};
      end
      T_I: begin
        gsel = gain_i_r;
        opb  = sum_r;
      end
      default: begin
        gsel = gain_d_r;
        opb  = {{14{diff_r[33]}}, diff_r};
      end
    endcase
    a_mag = gsel[31] ? (~gsel + 32'd1) : gsel;
    b_mag = opb[47] ? (~opb + 48'd1) : opb;

    // floor of the signed product >> 16, saturated at 2^46
    rounded  = neg_r ? ({1'b0, mrsp.prod} + 81'hFFFF) : {1'b0, mrsp.prod};
    shifted  = rounded[80:16];
    term_nxt = (shifted > {18'b0, TERM_LIMIT}) ? TERM_LIMIT : shifted[46:0];

    integ_ok = !gain_i_r[31] && (gain_i_r != 32'sd0)
             && (mrsp.prod < {33'b0, out_max_r, 16'b0})
             && (mrsp.prod > {33'b0, out_min_r, 16'b0});

    acc_abs = acc_r[48] ? (~acc_r + 49'd1) : acc_r;
    oc_mag  = '0;
    if (acc_abs > {18'b0, out_max_r}) begin
      oc_mag    = {1'b0, out_max_r};
      drive_nxt = acc_r[48] ? (~oc_mag + 32'd1) : oc_mag;
    end else if (acc_abs < {18'b0, out_min_r}) begin
      oc_mag    = {1'b0, out_min_r};
      drive_nxt = acc_r[48] ? (~oc_mag + 32'd1) : oc_mag;
    end else begin
      drive_nxt = acc_r[31:0];
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (cmd_t'(in_cmd) == CMD_SAMPLE && en_r) ? S_CLMP : S_DONE;
        end
      end
      S_CLMP:  state_nxt = S_ERR;
      S_ERR:   state_nxt = S_WRAP;
      S_WRAP:  state_nxt = S_SAT;
      S_SAT:   state_nxt = S_CAND;
      S_CAND:  state_nxt = S_MSET;
      S_MSET:  state_nxt = S_MGO;
      S_MGO:   state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mrsp.done) begin
          state_nxt = S_MPOST;
        end
      end
      S_MPOST: state_nxt = (k_r == T_INT) ? S_MSET : S_MACC;
      S_MACC:  state_nxt = (k_r == T_D) ? S_OCLAMP : S_MSET;
      S_OCLAMP: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    mul_start = (state_r == S_MGO);
    out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;

  // hold configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= T_INT;
      en_r         <= 1'b0;
      sum_r        <= '0;
      prev_r       <= '0;
      last_error_r <= '0;
      drive_r      <= '0;
      out_valid_r  <= 1'b0;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      in_min_r     <= '0;
      in_max_r     <= '0;
      out_min_r    <= '0;
      out_max_r    <= OUT_MAX_RESET;
      cont_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[4:2]))
          REG_GAIN_P:  gain_p_r  <= pwdata;
          REG_GAIN_I:  gain_i_r  <= pwdata;
          REG_GAIN_D:  gain_d_r  <= pwdata;
          REG_IN_MIN:  in_min_r  <= pwdata[30:0];
          REG_IN_MAX:  in_max_r  <= pwdata[30:0];
          REG_OUT_MIN: out_min_r <= pwdata[30:0];
          REG_OUT_MAX: out_max_r <= pwdata[30:0];
          REG_CONT:    cont_r    <= pwdata[0];
          default:     ;
        endcase
      end

      // commands take effect on acceptance; a disabled sample changes nothing
      if (in_acc) begin
        unique case (cmd_t'(in_cmd))
          CMD_SAMPLE:  ;
          CMD_ENABLE:  en_r <= 1'b1;
          CMD_DISABLE: en_r <= 1'b0;
          CMD_RESET: begin
            en_r    <= 1'b0;
            sum_r   <= '0;
            prev_r  <= '0;
            drive_r <= '0;
          end
          default: ;
        endcase
      end

      case (state_r)
        S_CLMP:  k_r <= T_INT;
        S_SAT:   last_error_r <= e_sat;
        S_MPOST: begin
          if (k_r == T_INT) begin
            if (integ_ok) begin
              sum_r <= cand_r;
            end
            k_r <= T_P;
          end
        end
        S_MACC:  k_r <= term_t'(k_r + 2'd1);
        S_OCLAMP: begin
          drive_r <= drive_nxt;
          prev_r  <= last_error_r;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // advance the per-sample scratch registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r <= in_measurement;
      tgt_r  <= in_target;
    end
    case (state_r)
      S_CLMP: begin
        if (in_clamp_on) begin
          meas_r <= mag_clamp32(meas_r, in_min_r, in_max_r);
          tgt_r  <= mag_clamp32(tgt_r, in_min_r, in_max_r);
        end
        acc_r <= '0;
      end
      S_ERR:  err_r <= {{3{tgt_r[31]}}, tgt_r} - {{3{meas_r[31]}}, meas_r};
      S_WRAP: begin
        if (cont_r && wrap_hit) begin
          err_r <= err_wrapped;
        end
      end
      S_CAND: begin
        cand_r <= cand_sat;
        diff_r <= diff_nxt;
      end
      S_MSET: begin
        mul_a_r <= a_mag;
        mul_b_r <= b_mag;
        neg_r   <= gsel[31] ^ opb[47];
      end
      S_MPOST: term_r <= term_nxt;
      S_MACC:  acc_r <= acc_r + (neg_r ? -$signed({2'b00, term_r}) : $signed({2'b00, term_r}));
      default: ;
    endcase
  end

  // result register: a finished item waits here while the next is accepted
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive      <= drive_r;
      out_loop_error <= last_error_r;
      out_running    <= en_r;
    end
  end

  assign out_valid = out_valid_r;

  // configuration read-back
  assign pready = 1'b1;
  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_GAIN_P:  prdata = gain_p_r;
      REG_GAIN_I:  prdata = gain_i_r;
      REG_GAIN_D:  prdata = gain_d_r;
      REG_IN_MIN:  prdata = {1'b0, in_min_r};
      REG_IN_MAX:  prdata = {1'b0, in_max_r};
      REG_OUT_MIN: prdata = {1'b0, out_min_r};
      REG_OUT_MAX: prdata = {1'b0, out_max_r};
      REG_CONT:    prdata = {31'b0, cont_r};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> state_r == S_MWAIT)
    else $error("multiplier finished outside its wait state");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised without a finished item");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_stall) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished item not moved to the result register");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |=> state_r == S_MWAIT)
    else $error("multiplier started without waiting for it");

endmodule

// ----- design/pid_mul.sv -----
// Radix-2 shift-add multiplier for unsigned magnitudes, one multiplier bit per cycle.
// Depends on pid_pkg for widths and the request/response structs.
module pid_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  pid_pkg::mul_req_t req,
  output pid_pkg::mul_rsp_t rsp
);
  import pid_pkg::*;

  logic [MUL_P_W-1:0]   acc_r;
  logic [MUL_B_W-1:0]   b_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [MUL_B_W:0]     part;

  assign part = {1'b0, acc_r[MUL_P_W-1:MUL_A_W]} + (acc_r[0] ? {1'b0, b_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= {{(MUL_P_W-MUL_A_W){1'b0}}, req.a};
      b_r   <= req.b;
    end else if (busy_r) begin
      acc_r <= {part, acc_r[MUL_A_W-1:1]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule
